### sv/selm_pkg.sv
// Package for the shared/exclusive lock manager: payload structs, event codes,
// and the command/status structs between controller and datapath. No dependencies.
`default_nettype none
package selm_pkg;

    localparam logic [2:0] EV_GRANTED    = 3'd0;
    localparam logic [2:0] EV_QUEUED     = 3'd1;
    localparam logic [2:0] EV_NOT_AVAIL  = 3'd2;
    localparam logic [2:0] EV_RELEASED   = 3'd3;
    localparam logic [2:0] EV_NOT_HELD   = 3'd4;
    localparam logic [2:0] EV_QUEUE_FULL = 3'd5;
    localparam logic [2:0] EV_TABLE_FULL = 3'd6;

    typedef struct packed {
        logic       opcode;
        logic [7:0] lock_id;
        logic       want_shared;
        logic       try_only;
        logic [7:0] requester_tag;
    } in_req_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] out_lock_id;
        logic       out_shared;
        logic [7:0] out_tag;
        logic       last;
    } out_req_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture input request, clear scan pointers
        logic tscan;       // step table scan for request id
        logic wscan;       // step table scan for current waiter id
        logic wnext;       // advance waiter index, restart table scan
        logic do_take;     // take the request's lock (grant)
        logic do_enq;      // push request into wait queue
        logic do_rel;      // lower count / free the found entry
        logic do_wtake;    // take the current waiter's lock
        logic shift;       // one shift step of queue removal
        logic shift_done;  // decrement wait count
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       is_release;
        logic       tdone;      // table scan finished
        logic       found;
        logic       has_free;
        logic       grant_ok;   // found entry accepts another shared holder
        logic       if_avail;
        logic       q_full;
        logic       wdone;      // waiter index reached wait count
        logic       shift_end;  // shift pointer at end
    } dp_sts_t;

endpackage
`default_nettype wire

### sv/selm_ctrl.sv
// Controller state machine of the lock manager.
// Depends on selm_pkg.
`default_nettype none
module selm_ctrl
    import selm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire logic    out_fire,
    input  wire logic    out_busy,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd,
    output logic         emit,
    output logic [2:0]   emit_ev,
    output logic         emit_wait,
    output logic         emit_last
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TSCAN = 3'd1;
    localparam logic [2:0] S_WSCAN = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_EMIT2 = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        emit       = 1'b0;
        emit_ev    = EV_GRANTED;
        emit_wait  = 1'b0;
        emit_last  = 1'b1;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_TSCAN;
                end
            end
            S_TSCAN:
            begin
                if (!sts.tdone)
                    cmd.tscan = 1'b1;
                else if (!out_busy)
                begin
                    emit = 1'b1;
                    if (sts.is_release)
                    begin
                        if (!sts.found)
                        begin
                            emit_ev    = EV_NOT_HELD;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.do_rel = 1'b1;
                            emit       = 1'b0;
                            state_next = S_WSCAN;
                        end
                    end
                    else
                    begin
                        state_next = S_IDLE;
                        if (sts.found ? sts.grant_ok : sts.has_free)
                        begin
                            emit_ev     = EV_GRANTED;
                            cmd.do_take = 1'b1;
                        end
                        else if (!sts.found)
                            emit_ev = EV_TABLE_FULL;
                        else if (sts.if_avail)
                            emit_ev = EV_NOT_AVAIL;
                        else if (sts.q_full)
                            emit_ev = EV_QUEUE_FULL;
                        else
                        begin
                            emit_ev    = EV_QUEUED;
                            cmd.do_enq = 1'b1;
                        end
                    end
                end
            end
            S_WSCAN:
            begin
                if (sts.wdone)
                begin
                    if (!out_busy)
                    begin
                        emit       = 1'b1;
                        emit_ev    = EV_RELEASED;
                        state_next = S_IDLE;
                    end
                end
                else if (!sts.tdone)
                    cmd.wscan = 1'b1;
                else if ((sts.found && sts.grant_ok) || (!sts.found && sts.has_free))
                begin
                    cmd.do_wtake = 1'b1;
                    state_next   = S_SHIFT;
                end
                else
                    cmd.wnext = 1'b1;
            end
            S_SHIFT:
            begin
                if (sts.shift_end)
                begin
                    cmd.shift_done = 1'b1;
                    state_next     = S_EMIT2;
                end
                else
                    cmd.shift = 1'b1;
            end
            S_EMIT2:
            begin
                if (!out_busy)
                begin
                    emit       = 1'b1;
                    emit_ev    = EV_RELEASED;
                    emit_last  = 1'b0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!out_busy || out_fire)
                begin
                    if (!out_busy)
                    begin
                        emit       = 1'b1;
                        emit_ev    = EV_GRANTED;
                        emit_wait  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### sv/selm_dp.sv
// Datapath of the lock manager: lock table, wait queue, scan pointers, held waiter.
// Depends on selm_pkg.
`default_nettype none
module selm_dp
    import selm_pkg::*;
#(
    parameter int LOCK_SLOTS  = 16,
    parameter int WAIT_DEPTH  = 8,
    parameter int MAX_HOLDERS = 255
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire in_req_t in_data,
    input  wire dp_cmd_t cmd,
    output dp_sts_t   sts,
    output logic [7:0] req_id,
    output logic       req_sh,
    output logic [7:0] req_tag,
    output logic       rel_sh,
    output logic [7:0] w_id,
    output logic       w_sh,
    output logic [7:0] w_tag
);
    localparam int SW = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
    localparam int WW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int HW = $clog2(MAX_HOLDERS + 1);
    localparam int SC = $clog2(LOCK_SLOTS + 1);
    localparam int WC = $clog2(WAIT_DEPTH + 1);
    localparam logic [HW-1:0] HMAX = HW'(MAX_HOLDERS);

    logic [LOCK_SLOTS-1:0] ev_reg;
    logic [7:0]  eid_reg [LOCK_SLOTS];
    logic        esh_reg [LOCK_SLOTS];
    logic [HW-1:0] eh_reg [LOCK_SLOTS];
    logic [7:0]  wid_reg [WAIT_DEPTH];
    logic        wsh_reg [WAIT_DEPTH];
    logic [7:0]  wtag_reg [WAIT_DEPTH];
    logic [WC-1:0] wcnt_reg;

    in_req_t     req_reg;
    logic        relsh_reg;
    logic [SC-1:0] tptr_reg;
    logic [WC-1:0] wptr_reg;
    logic [WC-1:0] sptr_reg;
    logic        found_reg, free_reg;
    logic [SW-1:0] fidx_reg, freeidx_reg;
    logic [7:0]  hid_reg, htag_reg;
    logic        hsh_reg;

    // key being searched or taken: request id or current waiter
    logic [7:0] key;
    logic key_sh;
    logic [SW-1:0] ti;
    logic [WW-1:0] wi, si;
    assign wi  = wptr_reg[WW-1:0];
    assign si  = sptr_reg[WW-1:0];
    assign ti  = tptr_reg[SW-1:0];
    assign key = (cmd.wscan || cmd.do_wtake) ? wid_reg[wi] : req_reg.lock_id;
    // mode is only needed for requests and for waiters during a release
    assign key_sh = req_reg.opcode ? wsh_reg[wi] : req_reg.want_shared;

    assign sts.is_release = req_reg.opcode;
    assign sts.tdone      = tptr_reg == SC'(LOCK_SLOTS);
    assign sts.found      = found_reg;
    assign sts.has_free   = free_reg;
    assign sts.grant_ok   = key_sh && esh_reg[fidx_reg] && (eh_reg[fidx_reg] < HMAX);
    assign sts.if_avail   = req_reg.try_only;
    assign sts.q_full     = wcnt_reg >= WC'(WAIT_DEPTH);
    assign sts.wdone      = wptr_reg >= wcnt_reg;
    assign sts.shift_end  = (sptr_reg + 1'b1) >= wcnt_reg;

    assign req_id  = req_reg.lock_id;
    assign req_sh  = req_reg.want_shared;
    assign req_tag = req_reg.requester_tag;
    assign rel_sh  = relsh_reg;
    assign w_id    = hid_reg;
    assign w_sh    = hsh_reg;
    assign w_tag   = htag_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_reg   <= '0;
            wcnt_reg <= '0;
            tptr_reg <= '0;
            wptr_reg <= '0;
            sptr_reg <= '0;
            found_reg <= 1'b0;
            free_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load || cmd.wnext || cmd.do_rel)
            begin
                tptr_reg  <= '0;
                found_reg <= 1'b0;
                free_reg  <= 1'b0;
            end
            if (cmd.load)
                wptr_reg <= '0;
            if (cmd.wnext)
                wptr_reg <= wptr_reg + 1'b1;
            if (cmd.tscan || cmd.wscan)
            begin
                tptr_reg <= tptr_reg + 1'b1;
                if (ev_reg[ti] && eid_reg[ti] == key && !found_reg)
                    found_reg <= 1'b1;
                if (!ev_reg[ti] && !free_reg)
                    free_reg <= 1'b1;
            end
            if (cmd.do_take || cmd.do_wtake)
            begin
                if (!found_reg)
                    ev_reg[freeidx_reg] <= 1'b1;
            end
            if (cmd.do_rel)
            begin
                if (!(esh_reg[fidx_reg] && eh_reg[fidx_reg] > HW'(1)))
                    ev_reg[fidx_reg] <= 1'b0;
            end
            if (cmd.do_enq)
                wcnt_reg <= wcnt_reg + 1'b1;
            if (cmd.do_wtake)
                sptr_reg <= wptr_reg;
            if (cmd.shift)
                sptr_reg <= sptr_reg + 1'b1;
            if (cmd.shift_done)
                wcnt_reg <= wcnt_reg - 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= in_data;
        if (cmd.tscan || cmd.wscan)
        begin
            if (ev_reg[ti] && eid_reg[ti] == key && !found_reg)
                fidx_reg <= ti;
            if (!ev_reg[ti] && !free_reg)
                freeidx_reg <= ti;
        end
        if (cmd.do_take || cmd.do_wtake)
        begin
            if (found_reg)
                eh_reg[fidx_reg] <= eh_reg[fidx_reg] + 1'b1;
            else
            begin
                eid_reg[freeidx_reg] <= key;
                esh_reg[freeidx_reg] <= key_sh;
                eh_reg[freeidx_reg]  <= HW'(1);
            end
        end
        if (cmd.do_wtake)
        begin
            hid_reg  <= wid_reg[wi];
            hsh_reg  <= wsh_reg[wi];
            htag_reg <= wtag_reg[wi];
        end
        if (cmd.do_rel)
        begin
            relsh_reg <= esh_reg[fidx_reg];
            if (esh_reg[fidx_reg] && eh_reg[fidx_reg] > HW'(1))
                eh_reg[fidx_reg] <= eh_reg[fidx_reg] - 1'b1;
        end
        if (cmd.do_enq)
        begin
            wid_reg[wcnt_reg[WW-1:0]]  <= req_reg.lock_id;
            wsh_reg[wcnt_reg[WW-1:0]]  <= req_reg.want_shared;
            wtag_reg[wcnt_reg[WW-1:0]] <= req_reg.requester_tag;
        end
        if (cmd.shift)
        begin
            wid_reg[si]  <= wid_reg[WW'(sptr_reg + 1'b1)];
            wsh_reg[si]  <= wsh_reg[WW'(sptr_reg + 1'b1)];
            wtag_reg[si] <= wtag_reg[WW'(sptr_reg + 1'b1)];
        end
    end
endmodule
`default_nettype wire

### sv/shared_exclusive_lock_manager.sv
// Shared/exclusive lock manager.
// Channels: in_valid/in_ready/in_data carry one request (request or release
// of a numeric lock id); out_valid/out_ready/out_data carry result events.
// A request yields one event. A release yields one event, or two (released,
// then grant of the first grantable waiter), with last set on the final one.
// The lock table is scanned one slot per cycle. A release also scans the
// wait queue, rescanning the table for each waiter examined, and removing the
// granted waiter shifts the queue one slot per cycle. One request is in work at a time.
// Reset clears the table valid bits and the queue count; no clearing pass.
// The result sits in an output register; a stalled receiver holds the
// controller until the register is free, and in_ready stays low meanwhile.
// Depends on selm_pkg, selm_ctrl and selm_dp.
`default_nettype none
module shared_exclusive_lock_manager
    import selm_pkg::*;
#(
    parameter int LOCK_SLOTS  = 16,
    parameter int WAIT_DEPTH  = 8,
    parameter int MAX_HOLDERS = 255
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire in_req_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output out_req_t     out_data
);
    dp_cmd_t cmd;
    dp_sts_t sts;
    logic emit, emit_wait, emit_last;
    logic [2:0] emit_ev;
    logic [7:0] req_id, req_tag, w_id, w_tag;
    logic req_sh, rel_sh, w_sh;
    logic valid_reg;
    out_req_t data_reg;

    selm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_fire(out_valid && out_ready), .out_busy(valid_reg),
        .sts(sts), .cmd(cmd), .emit(emit), .emit_ev(emit_ev),
        .emit_wait(emit_wait), .emit_last(emit_last)
    );

    selm_dp #(
        .LOCK_SLOTS(LOCK_SLOTS), .WAIT_DEPTH(WAIT_DEPTH), .MAX_HOLDERS(MAX_HOLDERS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd), .sts(sts),
        .req_id(req_id), .req_sh(req_sh), .req_tag(req_tag), .rel_sh(rel_sh),
        .w_id(w_id), .w_sh(w_sh), .w_tag(w_tag)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (emit)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            data_reg.event_res   <= emit_ev;
            data_reg.out_lock_id <= emit_wait ? w_id : req_id;
            data_reg.out_tag     <= emit_wait ? w_tag : req_tag;
            data_reg.last        <= emit_last;
            if (emit_wait)
                data_reg.out_shared <= w_sh;
            else if (emit_ev == EV_RELEASED)
                data_reg.out_shared <= rel_sh;
            else if (emit_ev == EV_NOT_HELD)
                data_reg.out_shared <= 1'b0;
            else
                data_reg.out_shared <= req_sh;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule
`default_nettype wire
